// ===== rtl/cfa_pkg.sv =====
// Shared constants for the frame allocator: field widths and command, mode and status codes.
`default_nettype none
package cfa_pkg;

	localparam int CMD_W       = 1;
	localparam int RUN_LEN_W   = 7;
	localparam int BASE_W      = 6;
	localparam int STATUS_W    = 1;
	localparam int FRAME_W     = 6;
	localparam int PROBE_W     = 7;
	localparam int MODE_W      = 2;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RSVD  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK   = 1'b0;
	localparam logic [STATUS_W-1:0] ST_FAIL = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/contiguous_frame_allocator.sv =====
// Top level of the contiguous frame allocator: command sequencer, serial scan and result register.
`default_nettype none
// Usage
//   Command channel: present cmd, run_length and base_frame with start; the item is
//   taken at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with status, frame_index and
//   probe_count; the receiver must take it in that cycle, nothing holds it back.
//   Config: cfg_we with cfg_wdata writes placement_mode (0 first, 1 best, 2 next fit).
// Timing
//   The occupancy bits sit in a one-port-read memory and are probed one frame a cycle,
//   so an allocate holds busy for its scan and, on success, for a write sweep over
//   run_length frames; done rises as busy falls, after a failing scan or the sweep.
//   A free clears its frames one a cycle in the write sweep. A bad length or the reserved
//   mode answers in the cycle after the command and never raises busy.
//   Items are handled one at a time; otherwise busy stays high until the result strobe.
// Reset
//   arst_n clears control state and placement_mode. A clearing pass then marks every
//   frame free; busy is high during it. Config writes are taken at any time, including
//   the clearing pass.
module contiguous_frame_allocator #(
	parameter int NUM_FRAMES = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [cfa_pkg::CMD_W-1:0]        cmd,
	input  logic [cfa_pkg::RUN_LEN_W-1:0]    run_length,
	input  logic [cfa_pkg::BASE_W-1:0]       base_frame,
	output logic                             done,
	output logic [cfa_pkg::STATUS_W-1:0]     status,
	output logic [cfa_pkg::FRAME_W-1:0]      frame_index,
	output logic [cfa_pkg::PROBE_W-1:0]      probe_count,
	input  logic                             cfg_we,
	input  logic [cfa_pkg::MODE_W-1:0]       cfg_wdata
);
	import cfa_pkg::*;

	// frame index, count/run width (holds NUM_FRAMES + 1 and any length), write cursor width
	localparam int FW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CW  = (FW + 1 > RUN_LEN_W) ? FW + 1 : RUN_LEN_W;
	localparam int FAW = (FW + 1 > BASE_W + 2) ? FW + 1 : BASE_W + 2;

	typedef logic [FW-1:0]  fidx_t;
	typedef logic [CW-1:0]  cnt_t;
	typedef logic [FAW-1:0] wptr_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_WRITE
	} state_t;

	state_t              state_q;
	logic [MODE_W-1:0]   mode_q;
	logic [MODE_W-1:0]   smode_q;
	fidx_t               next_start_q;
	fidx_t               clr_q;

	// scan issue side and the probe in flight (aligned with memory read data)
	fidx_t               iss_idx_q;
	cnt_t                iss_left_q;
	logic                p_vld_s1;
	fidx_t               p_idx_s1;

	// scan bookkeeping
	cnt_t                len_q;
	cnt_t                run_len_q;
	fidx_t               run_base_q;
	cnt_t                best_len_q;
	fidx_t               best_base_q;
	logic                best_found_q;
	cnt_t                probes_q;

	// serial write sweep
	wptr_t               wr_addr_q;
	wptr_t               wr_end_q;
	logic                wr_bit_q;

	// result register
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [FRAME_W-1:0]  frame_q;
	logic [PROBE_W-1:0]  probe_q;

	// memory port
	logic                mem_we;
	fidx_t               mem_waddr;
	logic                mem_wdata;
	fidx_t               mem_raddr;
	logic                rd_used;

	// scan step
	cnt_t                eff_run;
	cnt_t                run_new;
	fidx_t               base_new;
	cnt_t                probes_new;
	logic                cell_free;
	logic                last_probe;
	logic                best_cand;
	logic                scan_end;
	logic                scan_ok;
	fidx_t               scan_base;
	wptr_t               alloc_end;

	// command decode
	logic                accept;
	logic                bad_len;
	fidx_t               start_idx;
	wptr_t               wr_in_range;

	function automatic logic smode_next(input logic [MODE_W-1:0] m);
		return m == MODE_NEXT;
	endfunction

	cfa_bitmap #(
		.DEPTH (NUM_FRAMES),
		.AW    (FW)
	) u_bitmap (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd_used)
	);

	assign accept  = start && (state_q == S_IDLE);
	assign bad_len = (run_length == '0) || (CW'(run_length) > CW'(NUM_FRAMES));
	// next fit starts at the saved pointer; an out-of-range pointer counts as zero
	assign start_idx = (smode_next(mode_q) && (CW'(next_start_q) < CW'(NUM_FRAMES))) ?
		next_start_q : '0;
	assign wr_in_range = wptr_t'(NUM_FRAMES);

	// Drive the memory ports: writes for the clearing pass and write sweep, reads for the scan.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = 1'b0;
		mem_raddr = iss_idx_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 1'b0;
			end
			S_WRITE: begin
				mem_we    = (wr_addr_q != wr_end_q) && (wr_addr_q < wr_in_range);
				mem_waddr = FW'(wr_addr_q);
				mem_wdata = wr_bit_q;
			end
			default: begin
			end
		endcase
	end

	// Judge one probed frame. A run restarts at frame zero, so next fit never joins
	// a run across the wrap.
	always_comb begin
		cell_free  = !rd_used;
		eff_run    = (p_idx_s1 == '0) ? '0 : run_len_q;
		run_new    = cell_free ? eff_run + CW'(1) : '0;
		base_new   = (cell_free && (eff_run == '0)) ? p_idx_s1 : run_base_q;
		probes_new = probes_q + CW'(1);
		last_probe = probes_new == CW'(NUM_FRAMES);
		best_cand  = !cell_free && (eff_run >= len_q) && (eff_run < best_len_q);
		scan_end   = 1'b0;
		scan_ok    = 1'b0;
		scan_base  = base_new;
		case (smode_q)
			MODE_BEST: begin
				if (best_cand && (eff_run == len_q)) begin
					// exact fit closed by this used frame
					scan_end  = 1'b1;
					scan_ok   = 1'b1;
					scan_base = run_base_q;
				end else if (last_probe) begin
					scan_end = 1'b1;
					if (cell_free && (run_new >= len_q) && (run_new < best_len_q)) begin
						scan_ok   = 1'b1;
						scan_base = base_new;
					end else if (best_cand) begin
						scan_ok   = 1'b1;
						scan_base = run_base_q;
					end else if (best_found_q) begin
						scan_ok   = 1'b1;
						scan_base = best_base_q;
					end
				end
			end
			default: begin
				if (cell_free && (run_new >= len_q)) begin
					scan_end = 1'b1;
					scan_ok  = 1'b1;
				end else if (last_probe) begin
					scan_end = 1'b1;
				end
			end
		endcase
		alloc_end = wptr_t'(scan_base) + wptr_t'(len_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			mode_q       <= MODE_FIRST;
			smode_q      <= MODE_FIRST;
			next_start_q <= '0;
			clr_q        <= '0;
			iss_idx_q    <= '0;
			iss_left_q   <= '0;
			p_vld_s1     <= 1'b0;
			p_idx_s1     <= '0;
			len_q        <= '0;
			run_len_q    <= '0;
			run_base_q   <= '0;
			best_len_q   <= '0;
			best_base_q  <= '0;
			best_found_q <= 1'b0;
			probes_q     <= '0;
			wr_addr_q    <= '0;
			wr_end_q     <= '0;
			wr_bit_q     <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= ST_OK;
			frame_q      <= '0;
			probe_q      <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			unique case (state_q)
				S_CLEAR: begin
					// sweep every frame to free, one a cycle
					done_q <= 1'b0;
					clr_q  <= clr_q + FW'(1);
					if (CW'(clr_q) == CW'(NUM_FRAMES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					done_q <= accept && (cmd == CMD_ALLOC) &&
						(bad_len || (mode_q == MODE_RSVD));
					if (accept) begin
						if (cmd == CMD_FREE) begin
							wr_addr_q <= wptr_t'(base_frame);
							wr_end_q  <= wptr_t'(base_frame) + wptr_t'(run_length);
							wr_bit_q  <= 1'b0;
							status_q  <= ST_OK;
							frame_q   <= '0;
							probe_q   <= '0;
							state_q   <= S_WRITE;
						end else if (bad_len || (mode_q == MODE_RSVD)) begin
							// answer at once, no scan, no state change
							status_q <= ST_FAIL;
							frame_q  <= '0;
							probe_q  <= '0;
						end else begin
							smode_q      <= mode_q;
							len_q        <= CW'(run_length);
							iss_idx_q    <= start_idx;
							iss_left_q   <= CW'(NUM_FRAMES);
							p_vld_s1     <= 1'b0;
							run_len_q    <= '0;
							run_base_q   <= '0;
							best_len_q   <= CW'(NUM_FRAMES + 1);
							best_found_q <= 1'b0;
							probes_q     <= '0;
							state_q      <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					done_q <= p_vld_s1 && scan_end && !scan_ok;
					if (p_vld_s1 && scan_end) begin
						p_vld_s1   <= 1'b0;
						iss_left_q <= '0;
						probe_q    <= PROBE_W'(probes_new);
						if (scan_ok) begin
							status_q  <= ST_OK;
							frame_q   <= FRAME_W'(scan_base);
							wr_addr_q <= wptr_t'(scan_base);
							wr_end_q  <= alloc_end;
							wr_bit_q  <= 1'b1;
							if (smode_q == MODE_NEXT) begin
								next_start_q <= (alloc_end == wr_in_range) ?
									'0 : FW'(alloc_end);
							end
							state_q   <= S_WRITE;
						end else begin
							status_q <= ST_FAIL;
							frame_q  <= '0;
							state_q  <= S_IDLE;
						end
					end else begin
						// advance the read side one frame, wrapping at the top
						if (iss_left_q != '0) begin
							iss_left_q <= iss_left_q - CW'(1);
							iss_idx_q  <= (CW'(iss_idx_q) == CW'(NUM_FRAMES - 1)) ?
								'0 : iss_idx_q + FW'(1);
							p_vld_s1   <= 1'b1;
							p_idx_s1   <= iss_idx_q;
						end else begin
							p_vld_s1   <= 1'b0;
						end
						if (p_vld_s1) begin
							run_len_q  <= run_new;
							run_base_q <= base_new;
							probes_q   <= probes_new;
							if (best_cand) begin
								best_len_q   <= eff_run;
								best_base_q  <= run_base_q;
								best_found_q <= 1'b1;
							end
						end
					end
				end
				S_WRITE: begin
					// mark or clear one frame a cycle; drop frames past the end
					done_q <= !((wr_addr_q != wr_end_q) && (wr_addr_q < wr_in_range));
					if ((wr_addr_q != wr_end_q) && (wr_addr_q < wr_in_range)) begin
						wr_addr_q <= wr_addr_q + wptr_t'(1);
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign frame_index = frame_q;
	assign probe_count = probe_q;

	// result strobe only leaves the sequencer on its way back to idle
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");

	// a failed allocation never reports a base frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_FAIL)) |-> (frame_index == '0))
		else $error("failed result carries a frame index");

	// a free always runs through the write sweep before answering
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == CMD_FREE)) |=> (busy && !done))
		else $error("free command skipped the write sweep");

	// the scan never counts more probes than there are frames
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (probes_q < CW'(NUM_FRAMES)))
		else $error("probe count ran past the frame count");

endmodule
`default_nettype wire

// ===== rtl/cfa_bitmap.sv =====
// Frame occupancy memory: one write port, one read port with registered read data.
`default_nettype none
module cfa_bitmap #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic used_mem [DEPTH];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			used_mem[waddr] <= wdata;
		end
		rdata_q <= used_mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire
